FILE: design/txx_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the TEA/XTEA/XXTEA cipher.
// No dependencies.
package txx_pkg;

  localparam int WordW = 32;
  localparam int RoundW = 8;
  localparam int StepW = RoundW + 1;
  localparam int IndexW = 3;

  localparam logic [WordW-1:0] DELTA = 32'h9e37_79b9;

  localparam logic [1:0] VAR_TEA = 2'd0;
  localparam logic [1:0] VAR_XTEA = 2'd1;
  localparam logic [1:0] VAR_XXTEA = 2'd2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [IndexW-1:0] REG_KEY0 = 3'd0;
  localparam logic [IndexW-1:0] REG_KEY1 = 3'd1;
  localparam logic [IndexW-1:0] REG_KEY2 = 3'd2;
  localparam logic [IndexW-1:0] REG_KEY3 = 3'd3;
  localparam logic [IndexW-1:0] REG_ROUNDS = 3'd4;
  localparam logic [IndexW-1:0] REG_VARIANT = 3'd5;

  localparam logic [RoundW-1:0] ROUNDS_RESET = 8'd32;

  typedef logic [3:0][WordW-1:0] key_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic sub;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0] variant;
    logic       tgt_a;
  } mix_ctl_t;

endpackage

FILE: design/txx_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on txx_pkg.
interface txx_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [txx_pkg::IndexW-1:0]    index;
  logic [txx_pkg::WordW-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: design/txx_in_if.sv
`timescale 1ns / 1ps
// Block input channel: operation flag and two 32-bit words.
// Depends on txx_pkg.
interface txx_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [txx_pkg::WordW-1:0] word_first;
  logic [txx_pkg::WordW-1:0] word_second;

  modport source(output valid, operation, word_first, word_second, input ready);
  modport sink(input valid, operation, word_first, word_second, output ready);
endinterface

FILE: design/txx_out_if.sv
`timescale 1ns / 1ps
// Result channel: the two processed 32-bit words.
// Depends on txx_pkg.
interface txx_out_if;
  logic                      valid;
  logic                      ready;
  logic [txx_pkg::WordW-1:0] out_first;
  logic [txx_pkg::WordW-1:0] out_second;

  modport source(output valid, out_first, out_second, input ready);
  modport sink(input valid, out_first, out_second, output ready);
endinterface

FILE: design/tea_xtea_xxtea_block_cipher.sv
`timescale 1ns / 1ps
// TEA / XTEA / two-word XXTEA block cipher, 128-bit key, configurable rounds.
// One half round per cycle through a two-cell word ring, one block at a time: a
// block goes from accept through the run and flush states into the result register.
// The result register frees the ring while the result waits.
// Synchronous reset: idle, no result, key zero, 32 rounds, TEA.
module tea_xtea_xxtea_block_cipher (
  input logic     clk,
  input logic     rst,
  txx_cfg_if.sink cfg,
  txx_in_if.sink  blk,
  txx_out_if.source res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  state_t                            state;
  txx_pkg::key_t                     key;
  logic [txx_pkg::RoundW-1:0]        rounds;
  logic [1:0]                        variant;
  logic                              dec;
  logic [txx_pkg::StepW-1:0]         cnt;
  logic [txx_pkg::WordW-1:0]         sum;
  logic [txx_pkg::WordW-1:0]         res_first;
  logic [txx_pkg::WordW-1:0]         res_second;
  logic                              res_valid;

  logic                              accept;
  logic                              dec_in;
  logic [txx_pkg::StepW-1:0]         end_cnt;
  logic [txx_pkg::WordW+txx_pkg::RoundW-1:0] prod;
  logic [txx_pkg::WordW-1:0]         sum_init;
  logic                              sum_upd;
  logic [txx_pkg::WordW-1:0]         x;
  logic [txx_pkg::WordW-1:0]         y;
  logic [txx_pkg::WordW-1:0]         f;
  txx_pkg::cell_ctl_t                cell_ctl;
  txx_pkg::mix_ctl_t                 mix_ctl;

  assign cfg.ready = 1'b1;
  assign blk.ready = (state == ST_IDLE);
  assign accept = blk.valid & blk.ready;
  assign dec_in = (blk.operation == txx_pkg::OP_DECRYPT);

  assign end_cnt = {rounds, 1'b0} - txx_pkg::StepW'(1);
  assign prod = {{txx_pkg::RoundW{1'b0}}, txx_pkg::DELTA}
              * {{txx_pkg::WordW{1'b0}}, rounds};
  assign sum_init = dec_in ? prod[txx_pkg::WordW-1:0]
                  : ((variant == txx_pkg::VAR_XTEA) ? '0 : txx_pkg::DELTA);
  assign sum_upd = (variant == txx_pkg::VAR_XTEA) ? ~cnt[0] : cnt[0];

  assign cell_ctl.load = accept;
  assign cell_ctl.shift = (state == ST_RUN);
  assign cell_ctl.sub = dec;

  assign mix_ctl.variant = variant;
  assign mix_ctl.tgt_a = ~(cnt[0] ^ dec);

  assign res.valid = res_valid;
  assign res.out_first = res_first;
  assign res.out_second = res_second;

  txx_cell u_cell0 (
    .clk   (clk),
    .ctl   (cell_ctl),
    .init  (dec_in ? blk.word_second : blk.word_first),
    .nbr   (y),
    .delta ('0),
    .word  (x)
  );

  txx_cell u_cell1 (
    .clk   (clk),
    .ctl   (cell_ctl),
    .init  (dec_in ? blk.word_first : blk.word_second),
    .nbr   (x),
    .delta (f),
    .word  (y)
  );

  txx_mix u_mix (
    .y   (y),
    .sum (sum),
    .key (key),
    .ctl (mix_ctl),
    .f   (f)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      rounds <= txx_pkg::ROUNDS_RESET;
      variant <= txx_pkg::VAR_TEA;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        txx_pkg::REG_KEY0:    key[0] <= cfg.data;
        txx_pkg::REG_KEY1:    key[1] <= cfg.data;
        txx_pkg::REG_KEY2:    key[2] <= cfg.data;
        txx_pkg::REG_KEY3:    key[3] <= cfg.data;
        txx_pkg::REG_ROUNDS:  rounds <= cfg.data[txx_pkg::RoundW-1:0];
        txx_pkg::REG_VARIANT: variant <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res.ready && state != ST_FLUSH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            dec <= dec_in;
            cnt <= '0;
            sum <= sum_init;
            state <= (rounds == '0) ? ST_FLUSH : ST_RUN;
          end
        end
        ST_RUN: begin
          cnt <= cnt + txx_pkg::StepW'(1);
          if (sum_upd) begin
            sum <= dec ? (sum - txx_pkg::DELTA) : (sum + txx_pkg::DELTA);
          end
          if (cnt == end_cnt) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!res_valid || res.ready) begin
            res_first <= dec ? y : x;
            res_second <= dec ? x : y;
            res_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/txx_mix.sv
`timescale 1ns / 1ps
// Round function of TEA, XTEA and two-word XXTEA for one half round.
// Depends on txx_pkg.
module txx_mix (
  input  logic [txx_pkg::WordW-1:0] y,
  input  logic [txx_pkg::WordW-1:0] sum,
  input  txx_pkg::key_t             key,
  input  txx_pkg::mix_ctl_t         ctl,
  output logic [txx_pkg::WordW-1:0] f
);

  logic [txx_pkg::WordW-1:0] ka;
  logic [txx_pkg::WordW-1:0] kb;
  logic [1:0]                kidx_x;
  logic [1:0]                kidx_xx;
  logic [txx_pkg::WordW-1:0] tea_f;
  logic [txx_pkg::WordW-1:0] xtea_f;
  logic [txx_pkg::WordW-1:0] xx_f;

  always_comb begin
    ka = ctl.tgt_a ? key[0] : key[2];
    kb = ctl.tgt_a ? key[1] : key[3];
    kidx_x = ctl.tgt_a ? sum[1:0] : sum[12:11];
    kidx_xx = sum[3:2] ^ {1'b0, ~ctl.tgt_a};
    tea_f = ((y << 4) + ka) ^ (y + sum) ^ ((y >> 5) + kb);
    xtea_f = (((y << 4) ^ (y >> 5)) + y) ^ (sum + key[kidx_x]);
    xx_f = (((y >> 5) ^ (y << 2)) + ((y >> 3) ^ (y << 4)))
         ^ ((sum ^ y) + (key[kidx_xx] ^ y));
    unique case (ctl.variant)
      txx_pkg::VAR_TEA:   f = tea_f;
      txx_pkg::VAR_XTEA:  f = xtea_f;
      txx_pkg::VAR_XXTEA: f = xx_f;
      default:            f = '0;
    endcase
  end

endmodule

FILE: design/txx_cell.sv
`timescale 1ns / 1ps
// One cell of the word ring: holds a 32-bit word, takes its neighbor's word
// plus or minus an offset each step. Depends on txx_pkg.
module txx_cell (
  input  logic                      clk,
  input  txx_pkg::cell_ctl_t        ctl,
  input  logic [txx_pkg::WordW-1:0] init,
  input  logic [txx_pkg::WordW-1:0] nbr,
  input  logic [txx_pkg::WordW-1:0] delta,
  output logic [txx_pkg::WordW-1:0] word
);

  logic [txx_pkg::WordW-1:0] word_next;

  always_comb begin
    word_next = word;
    if (ctl.load) begin
      word_next = init;
    end else if (ctl.shift) begin
      word_next = ctl.sub ? (nbr - delta) : (nbr + delta);
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for tea_xtea_xxtea_block_cipher: cipher predictor, random stalls.
// Depends on txx_pkg, the txx_cfg_if / txx_in_if / txx_out_if interfaces and the cipher top.
module tb_top;
  import txx_pkg::*;

  localparam logic [1:0] VAR_UNDEF = 2'd3;
  localparam int RANDOM_ITEMS = 850;
  localparam int MAX_LATENCY = 2 * 255 + 2;
  localparam int LIMIT = 2_000_000;

  typedef struct packed {
    logic [WordW-1:0] first;
    logic [WordW-1:0] second;
  } block_t;

  typedef struct packed {
    logic   op;
    block_t data;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic [IndexW-1:0] cfg_index = '0;
  logic [WordW-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_op = 1'b0;
  logic [WordW-1:0]  in_first = '0;
  logic [WordW-1:0]  in_second = '0;
  logic              out_ready = 1'b0;

  txx_cfg_if cfg_ch ();
  txx_in_if  blk_ch ();
  txx_out_if res_ch ();

  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.index = cfg_index;
  assign cfg_ch.data = cfg_data;
  assign blk_ch.valid = in_valid;
  assign blk_ch.operation = in_op;
  assign blk_ch.word_first = in_first;
  assign blk_ch.word_second = in_second;
  assign res_ch.ready = out_ready;

  tea_xtea_xxtea_block_cipher uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .blk(blk_ch),
    .res(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  item_t  pending_q[$];
  block_t expected_q[$];
  int     n_pushed = 0;
  int     n_accepted = 0;
  int     errors = 0;
  int     cycles = 0;
  bit     no_idle_in = 1'b0;
  bit     no_idle_out = 1'b0;

  key_t              ph_key = '0;
  logic [RoundW-1:0] ph_rounds = ROUNDS_RESET;
  logic [1:0]        ph_variant = VAR_TEA;

  key_t              cur_key;
  logic [RoundW-1:0] cur_rounds;
  logic [1:0]        cur_variant;

  function automatic logic [WordW-1:0] tea_f(logic [WordW-1:0] v, logic [WordW-1:0] sum,
                                             logic [WordW-1:0] ka, logic [WordW-1:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  function automatic logic [WordW-1:0] xtea_f(logic [WordW-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic logic [WordW-1:0] xx_f(logic [WordW-1:0] y, logic [WordW-1:0] sum,
                                            logic [WordW-1:0] k);
    logic [WordW-1:0] p;
    logic [WordW-1:0] q;
    p = ((y >> 5) ^ (y << 2)) + ((y >> 3) ^ (y << 4));
    q = (sum ^ y) + (k ^ y);
    return p ^ q;
  endfunction

  function automatic block_t cipher_block(key_t key, logic [RoundW-1:0] rounds,
                                          logic [1:0] variant, logic op, block_t din);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] sum;
    logic [1:0]       e;
    block_t           dout;
    a = din.first;
    b = din.second;
    sum = (op == OP_DECRYPT) ? 32'(rounds) * DELTA : '0;
    for (int i = 0; i < int'(rounds); i++) begin
      case (variant)
        VAR_TEA: begin
          if (op == OP_ENCRYPT) begin
            sum = sum + DELTA;
            a = a + tea_f(b, sum, key[0], key[1]);
            b = b + tea_f(a, sum, key[2], key[3]);
          end else begin
            b = b - tea_f(a, sum, key[2], key[3]);
            a = a - tea_f(b, sum, key[0], key[1]);
            sum = sum - DELTA;
          end
        end
        VAR_XTEA: begin
          if (op == OP_ENCRYPT) begin
            a = a + (xtea_f(b) ^ (sum + key[sum[1:0]]));
            sum = sum + DELTA;
            b = b + (xtea_f(a) ^ (sum + key[sum[12:11]]));
          end else begin
            b = b - (xtea_f(a) ^ (sum + key[sum[12:11]]));
            sum = sum - DELTA;
            a = a - (xtea_f(b) ^ (sum + key[sum[1:0]]));
          end
        end
        VAR_XXTEA: begin
          if (op == OP_ENCRYPT) begin
            sum = sum + DELTA;
            e = sum[3:2];
            a = a + xx_f(b, sum, key[e]);
            b = b + xx_f(a, sum, key[e ^ 2'd1]);
          end else begin
            e = sum[3:2];
            b = b - xx_f(a, sum, key[e ^ 2'd1]);
            a = a - xx_f(b, sum, key[e]);
            sum = sum - DELTA;
          end
        end
        default: begin
        end
      endcase
    end
    dout.first = a;
    dout.second = b;
    return dout;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return ~(32'd1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  function automatic key_t rand_key();
    key_t k;
    case ($urandom_range(0, 7))
      0: k = '0;
      1: k = '1;
      default: begin
        for (int i = 0; i < 4; i++) k[i] = rand_word();
      end
    endcase
    return k;
  endfunction

  function automatic block_t rand_block();
    block_t b;
    b.first = rand_word();
    b.second = rand_word();
    return b;
  endfunction

  // input driver: one beat per handshake, random gaps between beats
  always @(posedge clk) begin : drive_blocks
    int    in_gap;
    item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!in_valid || blk_ch.ready) begin
      if (in_gap > 0 || pending_q.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        in_op <= nxt.op;
        in_first <= nxt.data.first;
        in_second <= nxt.data.second;
        in_gap = no_idle_in ? 0 : pick_gap();
      end
    end
  end

  // monitor: track config, predict on accepted blocks, check result beats
  always @(posedge clk) begin : watch_results
    int     stall;
    block_t got;
    block_t want;
    block_t din;
    if (rst) begin
      cur_key = '0;
      cur_rounds = ROUNDS_RESET;
      cur_variant = VAR_TEA;
      out_ready <= 1'b0;
      stall = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_KEY0: cur_key[0] = cfg_ch.data;
          REG_KEY1: cur_key[1] = cfg_ch.data;
          REG_KEY2: cur_key[2] = cfg_ch.data;
          REG_KEY3: cur_key[3] = cfg_ch.data;
          REG_ROUNDS: cur_rounds = cfg_ch.data[RoundW-1:0];
          REG_VARIANT: cur_variant = cfg_ch.data[1:0];
          default: begin
          end
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        got.first = res_ch.out_first;
        got.second = res_ch.out_second;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none got %h %h", $time, got.first,
                   got.second);
        end else begin
          want = expected_q.pop_front();
          if (got.first !== want.first) begin
            errors++;
            $display("%0t: out_first expected %h got %h", $time, want.first, got.first);
          end
          if (got.second !== want.second) begin
            errors++;
            $display("%0t: out_second expected %h got %h", $time, want.second, got.second);
          end
        end
      end
      if (blk_ch.valid && blk_ch.ready) begin
        din.first = blk_ch.word_first;
        din.second = blk_ch.word_second;
        expected_q.push_back(cipher_block(cur_key, cur_rounds, cur_variant,
                                          blk_ch.operation, din));
        n_accepted++;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall = no_idle_out ? 0 : pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push_item(logic op, block_t b);
    item_t it;
    it.op = op;
    it.data = b;
    pending_q.push_back(it);
    n_pushed++;
  endtask

  // encrypt-then-decrypt or the reverse, second beat fed the predicted output
  task automatic push_round_trip(block_t b);
    logic op;
    op = ($urandom_range(0, 1) == 0) ? OP_ENCRYPT : OP_DECRYPT;
    push_item(op, b);
    push_item((op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT,
              cipher_block(ph_key, ph_rounds, ph_variant, op, b));
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_accepted != n_pushed || expected_q.size() != 0);
  endtask

  task automatic cfg_write(logic [IndexW-1:0] idx, logic [WordW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(key_t k, logic [RoundW-1:0] rounds, logic [1:0] variant);
    int mode;
    wait_idle();
    mode = $urandom_range(0, 3);
    no_idle_in = (mode == 0 || mode == 1);
    no_idle_out = (mode == 0 || mode == 2);
    cfg_write(REG_KEY0, k[0]);
    cfg_write(REG_KEY1, k[1]);
    cfg_write(REG_KEY2, k[2]);
    cfg_write(REG_KEY3, k[3]);
    cfg_write(REG_ROUNDS, {{(WordW - RoundW){1'b0}}, rounds});
    cfg_write(REG_VARIANT, {{(WordW - 2){1'b0}}, variant});
    ph_key = k;
    ph_rounds = rounds;
    ph_variant = variant;
  endtask

  initial begin : stimulus
    block_t            corners[4];
    key_t              k;
    logic [RoundW-1:0] rounds;
    logic [1:0]        variant;
    int                n_random;
    int                n_phase;
    int                made;
    int                sel;
    bit                hold_mid;
    bit                first_phase;

    corners[0] = '{first: 32'h0000_0000, second: 32'h0000_0000};
    corners[1] = '{first: 32'hffff_ffff, second: 32'hffff_ffff};
    corners[2] = '{first: 32'h8000_0000, second: 32'h0000_0001};
    corners[3] = '{first: 32'h0000_0001, second: 32'h8000_0000};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: TEA, 32 rounds, zero key
    for (int i = 0; i < 4; i++) begin
      push_item(OP_ENCRYPT, corners[i]);
      push_item(OP_DECRYPT, corners[i]);
    end

    set_config('1, 8'd1, VAR_XXTEA);
    push_item(OP_ENCRYPT, corners[0]);
    push_item(OP_DECRYPT, corners[2]);
    k = rand_key();
    set_config(k, 8'd32, VAR_XTEA);
    push_item(OP_ENCRYPT, corners[1]);
    push_item(OP_DECRYPT, corners[3]);
    set_config(k, 8'd1, VAR_TEA);
    push_item(OP_ENCRYPT, corners[2]);
    push_item(OP_DECRYPT, corners[1]);
    set_config(k, 8'd1, VAR_XTEA);
    push_item(OP_ENCRYPT, corners[3]);
    push_item(OP_DECRYPT, corners[0]);
    set_config(rand_key(), 8'd255, VAR_TEA);
    push_round_trip(rand_block());
    set_config(rand_key(), 8'd255, VAR_XTEA);
    push_round_trip(rand_block());
    set_config(rand_key(), 8'd255, VAR_XXTEA);
    push_round_trip(rand_block());
    set_config(rand_key(), 8'd17, VAR_UNDEF);
    push_item(OP_ENCRYPT, rand_block());
    push_item(OP_DECRYPT, rand_block());

    n_random = 0;
    first_phase = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          rounds = 8'd255;
          n_phase = 6;
        end
        1: begin
          rounds = $urandom_range(65, 254);
          n_phase = 8;
        end
        2, 3, 4: begin
          rounds = $urandom_range(17, 64);
          n_phase = $urandom_range(30, 60);
        end
        default: begin
          rounds = $urandom_range(1, 16);
          n_phase = $urandom_range(50, 100);
        end
      endcase
      sel = $urandom_range(0, 9);
      if (sel < 3) variant = VAR_TEA;
      else if (sel < 6) variant = VAR_XTEA;
      else if (sel < 9) variant = VAR_XXTEA;
      else variant = VAR_UNDEF;
      if (n_phase > RANDOM_ITEMS - n_random) n_phase = RANDOM_ITEMS - n_random;
      set_config(rand_key(), rounds, variant);
      hold_mid = first_phase || ($urandom_range(0, 2) == 0);
      first_phase = 1'b0;
      made = 0;
      while (made < n_phase) begin
        if (hold_mid && made >= n_phase / 2) begin
          wait_idle();
          hold_mid = 1'b0;
        end
        if ($urandom_range(0, 9) < 4 && n_phase - made >= 2) begin
          push_round_trip(rand_block());
          made += 2;
        end else begin
          push_item(($urandom_range(0, 1) == 0) ? OP_ENCRYPT : OP_DECRYPT, rand_block());
          made++;
        end
      end
      n_random += n_phase;
    end

    wait_idle();
    repeat (MAX_LATENCY + 8) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
